### hw/rtl/decimal_seven_segment_writer_unit_assert.svh
// Assertion macros shared by the decimal seven-segment writer RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef DECIMAL_SEVEN_SEGMENT_WRITER_UNIT_ASSERT_SVH
`define DECIMAL_SEVEN_SEGMENT_WRITER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked only while reset is released.
`define DSSW_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("dssw assertion failed");
// Checked at every edge, including those during reset.
`define DSSW_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("dssw assertion failed");
`else
`define DSSW_ASSERT(lbl, clk_s, rstn_s, prop)
`define DSSW_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif

`endif

### hw/rtl/dssw_pkg.sv
// Types, constants and the segment pattern table for the decimal seven-segment writer.
// No dependencies.
package dssw_pkg;

  typedef logic [13:0] number_t;
  typedef logic [3:0]  digit_t;
  typedef logic [7:0]  seg_byte_t;
  typedef logic [2:0]  reg_addr_t;
  typedef logic [1:0]  beat_idx_t;
  // One pattern byte per digit position, index 0 is the ones digit.
  typedef logic [3:0][7:0] seg_word_t;

  localparam number_t NUM_MAX        = 14'd9999;
  localparam number_t NUM_THOUSAND   = 14'd1000;
  localparam number_t NUM_HUNDRED    = 14'd100;
  localparam number_t NUM_TEN        = 14'd10;

  // Reciprocals for exact division of values up to 9999.
  localparam number_t RECIP_1000     = 14'd8389;  // shift 23
  localparam number_t RECIP_100      = 14'd5243;  // shift 19
  localparam number_t RECIP_10       = 14'd6554;  // shift 16

  localparam seg_byte_t BLANK_PATTERN = 8'h00;

  localparam reg_addr_t ADDR_ONES      = 3'd1;
  localparam reg_addr_t ADDR_THOUSANDS = 3'd4;
  localparam beat_idx_t BEAT_FIRST     = 2'd0;
  localparam beat_idx_t BEAT_LAST      = 2'd3;

  // No-decode segment patterns for the digits zero through nine.
  function automatic seg_byte_t seg_pattern(digit_t d);
    seg_byte_t p;
    case (d)
      4'd0:    p = 8'h7E;
      4'd1:    p = 8'h30;
      4'd2:    p = 8'h6D;
      4'd3:    p = 8'h79;
      4'd4:    p = 8'h33;
      4'd5:    p = 8'h5B;
      4'd6:    p = 8'h5F;
      4'd7:    p = 8'h70;
      4'd8:    p = 8'h7F;
      4'd9:    p = 8'h7B;
      default: p = BLANK_PATTERN;
    endcase
    return p;
  endfunction

endpackage

### hw/rtl/dssw_encode.sv
// Clamps a binary number, splits it into four decimal digits and encodes them.
// Depends on dssw_pkg.
module dssw_encode (
  input  dssw_pkg::number_t   number,
  output dssw_pkg::seg_word_t patterns
);

  dssw_pkg::number_t nc;
  logic [27:0] p1k;
  logic [27:0] p100;
  logic [27:0] p10;
  logic [3:0]  q1k;
  logic [6:0]  q100;
  logic [9:0]  q10;
  dssw_pkg::digit_t d_th;
  dssw_pkg::digit_t d_hu;
  dssw_pkg::digit_t d_te;
  dssw_pkg::digit_t d_on;

  always_comb begin
    nc = (number > dssw_pkg::NUM_MAX) ? dssw_pkg::NUM_MAX : number;

    // Three independent reciprocal multiplies; the quotients are exact below 10000.
    p1k  = 28'(nc) * 28'(dssw_pkg::RECIP_1000);
    p100 = 28'(nc) * 28'(dssw_pkg::RECIP_100);
    p10  = 28'(nc) * 28'(dssw_pkg::RECIP_10);
    q1k  = p1k[26:23];
    q100 = p100[25:19];
    q10  = p10[25:16];

    // Each digit is a quotient minus ten times the next coarser quotient.
    d_th = q1k;
    d_hu = 4'(q100 - {q1k, 3'b000} - {2'b00, q1k, 1'b0});
    d_te = 4'(q10 - {q100, 3'b000} - {2'b00, q100, 1'b0});
    d_on = 4'(nc - {1'b0, q10, 3'b000} - {3'b000, q10, 1'b0});

    patterns[0] = dssw_pkg::seg_pattern(d_on);
    patterns[1] = (nc >= dssw_pkg::NUM_TEN) ? dssw_pkg::seg_pattern(d_te)
                                            : dssw_pkg::BLANK_PATTERN;
    patterns[2] = (nc >= dssw_pkg::NUM_HUNDRED) ? dssw_pkg::seg_pattern(d_hu)
                                                : dssw_pkg::BLANK_PATTERN;
    patterns[3] = (nc >= dssw_pkg::NUM_THOUSAND) ? dssw_pkg::seg_pattern(d_th)
                                                 : dssw_pkg::BLANK_PATTERN;
  end

endmodule

### hw/rtl/decimal_seven_segment_writer_unit.sv
// Top level of the decimal seven-segment writer.
// Depends on dssw_pkg, dssw_encode and decimal_seven_segment_writer_unit_assert.svh.

// Each accepted number (0 to 9999, larger values shown as 9999) produces four
// output beats, one display register write per cycle while out_ready is high:
// the ones digit at address 1, then tens, hundreds and thousands at address 4,
// with out_last high on the fourth. Digit positions above the highest nonzero
// digit carry the blank pattern 0x00, so zero shows as a single "0". The output
// port, which carries one write per cycle while out_ready is high, sets the
// throughput. When the result register is free, a number is first captured in
// the input register, and its encoded patterns are then loaded into the result
// register, which presents the first beat. The input register takes the next
// number while the current one is still being written out, so back-to-back
// numbers stream without gaps between their beats.

`include "decimal_seven_segment_writer_unit_assert.svh"

module decimal_seven_segment_writer_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dssw_pkg::number_t    in_number,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dssw_pkg::reg_addr_t  out_reg_addr,
  output dssw_pkg::seg_byte_t  out_seg_data,
  output logic                 out_last
);

  // Input register.
  logic                 a_valid_r, a_valid_nxt;
  dssw_pkg::number_t    a_num_r,   a_num_nxt;

  // Result register: the four patterns and the beat being shown.
  logic                 b_valid_r, b_valid_nxt;
  dssw_pkg::seg_word_t  pats_r,    pats_nxt;
  dssw_pkg::beat_idx_t  cnt_r,     cnt_nxt;

  dssw_pkg::seg_word_t  enc_pats;
  logic                 out_fire;
  logic                 b_done;
  logic                 a_move;
  logic                 in_fire;

  dssw_encode u_encode (
    .number   (a_num_r),
    .patterns (enc_pats)
  );

  // The result register frees up on the beat that hands off the thousands write,
  // so a waiting number moves in during that same cycle.
  assign out_fire = b_valid_r && out_ready;
  assign b_done   = out_fire && (cnt_r == dssw_pkg::BEAT_LAST);
  assign a_move   = a_valid_r && (!b_valid_r || b_done);
  assign in_ready = !a_valid_r || a_move;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    a_valid_nxt = a_valid_r;
    a_num_nxt   = a_num_r;
    if (in_fire) begin
      a_valid_nxt = 1'b1;
      a_num_nxt   = in_number;
    end else if (a_move) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    b_valid_nxt = b_valid_r;
    pats_nxt    = pats_r;
    cnt_nxt     = cnt_r;
    if (a_move) begin
      b_valid_nxt = 1'b1;
      pats_nxt    = enc_pats;
      cnt_nxt     = dssw_pkg::BEAT_FIRST;
    end else if (b_done) begin
      b_valid_nxt = 1'b0;
    end else if (out_fire) begin
      cnt_nxt     = cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      cnt_r     <= dssw_pkg::BEAT_FIRST;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    a_num_r <= a_num_nxt;
    pats_r  <= pats_nxt;
  end

  // Beat index 0 is the ones digit at the lowest register address.
  assign out_valid    = b_valid_r;
  assign out_reg_addr = dssw_pkg::ADDR_ONES + 3'(cnt_r);
  assign out_seg_data = pats_r[cnt_r];
  assign out_last     = (cnt_r == dssw_pkg::BEAT_LAST);

  `DSSW_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_valid && !a_valid_r)
  `DSSW_ASSERT(a_last_at_top, clk, rst_n,
    out_valid |-> (out_last == (out_reg_addr == dssw_pkg::ADDR_THOUSANDS)))
  `DSSW_ASSERT(a_addr_steps, clk, rst_n,
    out_valid && out_ready && !out_last |=>
      out_valid && (out_reg_addr == $past(out_reg_addr) + 3'd1))
  `DSSW_ASSERT(a_new_run_at_ones, clk, rst_n,
    a_move |=> out_valid && (out_reg_addr == dssw_pkg::ADDR_ONES))

endmodule
